// ----- rtl/nwps_pkg.sv -----
`timescale 1ns / 1ps
// Package for the nibble wildcard pattern scanner: command codes, field widths,
// parameter defaults and the nibble keep-mask helper. No dependencies.
package nwps_pkg;

	// Field widths fixed by the item and register formats.
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned INDEX_W    = 5;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned MARK_W     = 2;
	localparam int unsigned LEN_W      = 6;
	localparam int unsigned OFFSET_W   = 32;

	// Defaults for the top-level parameters.
	localparam int unsigned PATTERN_MAX_DEF = 32;
	localparam int unsigned OFFSET_BITS_DEF = 32;

	// Reset value of the length register.
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

	// Nibble keep masks.
	localparam logic [BYTE_W-1:0] KEEP_LOW_NIB  = 8'h0f;
	localparam logic [BYTE_W-1:0] KEEP_HIGH_NIB = 8'hf0;

	// Wildcard mark bits.
	localparam int unsigned MARK_HIGH_BIT = 0;
	localparam int unsigned MARK_LOW_BIT  = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_SCAN  = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	// Bits of a byte that take part in the compare under a wildcard mark.
	function automatic logic [BYTE_W-1:0] keep_mask(input logic [MARK_W-1:0] mark);
		logic [BYTE_W-1:0] keep;
		keep = '1;
		if (mark[MARK_HIGH_BIT]) begin
			keep = keep & KEEP_LOW_NIB;
		end
		if (mark[MARK_LOW_BIT]) begin
			keep = keep & KEEP_HIGH_NIB;
		end
		return keep;
	endfunction

endpackage

// ----- rtl/nwps_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pattern scanner: input item channel
// and result channel. Depends on nwps_pkg for field widths.
interface nwps_item_if;
	logic                           valid;
	logic                           ready;
	logic [nwps_pkg::CMD_W-1:0]     command;
	logic [nwps_pkg::INDEX_W-1:0]   entry_index;
	logic [nwps_pkg::BYTE_W-1:0]    entry_byte;
	logic [nwps_pkg::MARK_W-1:0]    entry_wildcard;
	logic [nwps_pkg::BYTE_W-1:0]    data_byte;
	logic                           last_byte;

	modport source (
		output valid, command, entry_index, entry_byte, entry_wildcard, data_byte,
			last_byte,
		input  ready
	);
	modport sink (
		input  valid, command, entry_index, entry_byte, entry_wildcard, data_byte,
			last_byte,
		output ready
	);
endinterface

interface nwps_result_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [nwps_pkg::OFFSET_W-1:0]  match_offset;

	modport source (
		output valid, found, match_offset,
		input  ready
	);
	modport sink (
		input  valid, found, match_offset,
		output ready
	);
endinterface

// ----- rtl/nwps_match.sv -----
`timescale 1ns / 1ps
// Parallel window compare: checks the newest len window bytes against the
// pattern under per-entry nibble wildcards. Depends on nwps_pkg.
module nwps_match #(
	parameter int unsigned PATTERN_MAX = nwps_pkg::PATTERN_MAX_DEF,
	parameter int unsigned ULEN_W      = $clog2(PATTERN_MAX + 1)
) (
	input  logic [nwps_pkg::BYTE_W-1:0] win   [PATTERN_MAX],
	input  logic [nwps_pkg::BYTE_W-1:0] pat   [PATTERN_MAX],
	input  logic [nwps_pkg::MARK_W-1:0] marks [PATTERN_MAX],
	input  logic [ULEN_W-1:0]           len,
	output logic                        hit
);
	import nwps_pkg::*;

	localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [PATTERN_MAX-1:0] entry_ok;

	// Pattern entry x lines up with window tap len-1-x (tap 0 is the newest byte).
	always_comb begin
		for (int x = 0; x < PATTERN_MAX; x++) begin
			logic [IDX_W-1:0] tap;
			tap = IDX_W'(int'(len) - 1 - x);
			if (x < int'(len)) begin
				entry_ok[x] = ((win[tap] ^ pat[x]) & keep_mask(marks[x])) == '0;
			end else begin
				entry_ok[x] = 1'b1;
			end
		end
	end

	assign hit = &entry_ok;

endmodule

// ----- rtl/nibble_wildcard_pattern_scanner_core.sv -----
`timescale 1ns / 1ps
// Top level of the nibble wildcard pattern scanner: input register, scan state,
// result register. Depends on nwps_pkg, nwps_if.sv and nwps_match.
//
// Wildcard byte-signature scanner. Load the pattern with load beats (entry
// index, byte, 2-bit wildcard mark: bit0 ignores the high nibble, bit1 the low
// nibble), set the length through cfg_we/cfg_wdata while the block is idle,
// open a region with a start beat, then stream the region with scan beats and
// flag the final one with last_byte. The block returns one result beat per
// region: found=1 with the offset of the first matching window, or found=0
// when the last byte passes without a match; later scan beats of the same
// region are dropped until the next start. Throughput is one beat per clock
// while the result side keeps up: every beat waits in the input register and
// its result is loaded into the result register as the beat moves on. The
// clock period is bounded by the compare of all PATTERN_MAX window taps
// against the pattern, done in parallel in nwps_match behind a length-selected
// tap mux. The result register lets the input register move on every cycle
// while the receiver keeps up. While a result waits untaken, the input
// register accepts at most one more beat and then holds it, with ready low,
// until the result is taken. The offset counter saturates at 2^OFFSET_BITS-1
// and the reported offset is the low 32 bits of that count less the length.
module nibble_wildcard_pattern_scanner_core #(
	parameter int unsigned PATTERN_MAX = nwps_pkg::PATTERN_MAX_DEF,
	parameter int unsigned OFFSET_BITS = nwps_pkg::OFFSET_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	nwps_item_if.sink                   item,
	nwps_result_if.source               result,
	input  logic                        cfg_we,
	input  logic [nwps_pkg::LEN_W-1:0]  cfg_wdata
);
	import nwps_pkg::*;

	localparam int unsigned IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int unsigned ULEN_W = $clog2(PATTERN_MAX + 1);
	localparam int unsigned CMP_W  = (OFFSET_BITS > ULEN_W) ? OFFSET_BITS : ULEN_W;

	// Input register stage.
	logic                valid_s1;
	logic [CMD_W-1:0]    command_s1;
	logic [INDEX_W-1:0]  entry_index_s1;
	logic [BYTE_W-1:0]   entry_byte_s1;
	logic [MARK_W-1:0]   entry_wildcard_s1;
	logic [BYTE_W-1:0]   data_byte_s1;
	logic                last_byte_s1;

	// Scan state.
	logic [BYTE_W-1:0]      window_q [PATTERN_MAX];
	logic [BYTE_W-1:0]      pattern_q [PATTERN_MAX];
	logic [MARK_W-1:0]      marks_q [PATTERN_MAX];
	logic [OFFSET_BITS-1:0] count_q;
	logic                   done_q;
	logic [LEN_W-1:0]       length_q;

	// Result register.
	logic                res_valid_q;
	logic                res_found_q;
	logic [OFFSET_W-1:0] res_offset_q;

	logic                   advance;
	logic                   fire;
	logic                   is_scan;
	logic [BYTE_W-1:0]      window_nxt [PATTERN_MAX];
	logic [OFFSET_BITS-1:0] count_nxt;
	logic [ULEN_W-1:0]      len_used;
	logic                   win_hit;
	logic                   full_enough;
	logic                   match_now;
	logic                   produce;
	logic [CMP_W-1:0]       offset_diff;

	// Stage 1 moves on when the result register is empty or being drained.
	assign advance    = !res_valid_q || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	// Length in use: zero acts as one, anything past the window depth is clamped.
	always_comb begin
		if (length_q == '0) begin
			len_used = ULEN_W'(1);
		end else if (int'(length_q) > int'(PATTERN_MAX)) begin
			len_used = ULEN_W'(PATTERN_MAX);
		end else begin
			len_used = ULEN_W'(length_q);
		end
	end

	// Window after shifting in the staged data byte; tap 0 is the newest.
	always_comb begin
		window_nxt[0] = data_byte_s1;
		for (int i = 1; i < PATTERN_MAX; i++) begin
			window_nxt[i] = window_q[i-1];
		end
	end

	assign count_nxt = (count_q == '1) ? count_q : count_q + OFFSET_BITS'(1);

	nwps_match #(
		.PATTERN_MAX (PATTERN_MAX),
		.ULEN_W      (ULEN_W)
	) u_match (
		.win   (window_nxt),
		.pat   (pattern_q),
		.marks (marks_q),
		.len   (len_used),
		.hit   (win_hit)
	);

	// A match needs at least len bytes of the region in the window.
	assign full_enough = CMP_W'(count_nxt) >= CMP_W'(len_used);
	assign match_now   = full_enough && win_hit;
	assign offset_diff = CMP_W'(count_nxt) - CMP_W'(len_used);
	assign is_scan     = (command_s1 == CMD_SCAN) && !done_q;
	assign produce     = fire && is_scan && (match_now || last_byte_s1);

	// Input register: take a beat whenever the stage is free or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			command_s1        <= item.command;
			entry_index_s1    <= item.entry_index;
			entry_byte_s1     <= item.entry_byte;
			entry_wildcard_s1 <= item.entry_wildcard;
			data_byte_s1      <= item.data_byte;
			last_byte_s1      <= item.last_byte;
		end
	end

	// Length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LEN_RESET;
		end else if (cfg_we) begin
			length_q <= cfg_wdata;
		end
	end

	// Pattern store and wildcard marks; loads past the depth are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				pattern_q[i] <= '0;
				marks_q[i]   <= '0;
			end
		end else if (fire && (command_s1 == CMD_LOAD)
				&& (int'(entry_index_s1) < int'(PATTERN_MAX))) begin
			pattern_q[IDX_W'(entry_index_s1)] <= entry_byte_s1;
			marks_q[IDX_W'(entry_index_s1)]   <= entry_wildcard_s1;
		end
	end

	// Window shift line. A start need not clear it: the byte count keeps
	// stale taps out of every compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				window_q[i] <= '0;
			end
		end else if (fire && is_scan) begin
			window_q <= window_nxt;
		end
	end

	// Region control: count bytes, close the region on its report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else if (fire) begin
			case (command_s1)
				CMD_START: begin
					count_q <= '0;
					done_q  <= 1'b0;
				end
				CMD_SCAN: begin
					if (!done_q) begin
						count_q <= count_nxt;
						if (match_now || last_byte_s1) begin
							done_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register: hold until taken, refill only when stage 1 advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= produce;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			res_found_q  <= match_now;
			res_offset_q <= match_now ? OFFSET_W'(offset_diff) : '0;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.found        = res_found_q;
	assign result.match_offset = res_offset_q;

endmodule

// ----- tb/tb_nibble_wildcard_pattern_scanner_core.sv -----
`timescale 1ns / 1ps
// Testbench for nibble_wildcard_pattern_scanner_core: drives load, start and scan
// beats, predicts match reports from its own scanner model and checks each result
// beat in order. Depends on nwps_pkg and the channel interfaces in nwps_if.sv.
module tb_nibble_wildcard_pattern_scanner_core;
	import nwps_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
	localparam int unsigned      WIN_DEPTH    = PATTERN_MAX_DEF;
	localparam longint unsigned  COUNT_TOP    = (64'd1 << OFFSET_BITS_DEF) - 64'd1;
	localparam int unsigned      RANDOM_BEATS = 950;
	// Long receiver hold-off, in cycles, used to fill the block and stall its input.
	localparam int unsigned      LONG_HOLD    = 120;
	// Quiet margin, in cycles, before touching the length register.
	localparam int unsigned      SETTLE_CYCLES = 6;

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [INDEX_W-1:0] idx;
		logic [BYTE_W-1:0]  pbyte;
		logic [MARK_W-1:0]  pmark;
		logic [BYTE_W-1:0]  dbyte;
		logic               last;
	} scan_beat_t;

	typedef struct {
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} match_report_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [LEN_W-1:0]    cfg_wdata;

	nwps_item_if   item_ch ();
	nwps_result_if result_ch ();

	nibble_wildcard_pattern_scanner_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Scanner model state, kept in step with every accepted beat.
	logic [BYTE_W-1:0] win_bytes [WIN_DEPTH];
	logic [BYTE_W-1:0] sig_bytes [WIN_DEPTH];
	logic [MARK_W-1:0] sig_marks [WIN_DEPTH];
	longint unsigned   seen_bytes;
	bit                region_closed;
	logic [LEN_W-1:0]  len_reg;

	match_report_t pending_reports [$];
	int unsigned   mismatch_count = 0;
	int unsigned   beats_taken = 0;
	// Drop all random idling on both sides while set.
	bit            calm = 1'b0;
	// Raised at a falling edge by a test, taken up by the result sink.
	bit            long_hold_req = 1'b0;

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(13, 40);
	endfunction

	// Bits of a byte that take part in the compare under a wildcard mark.
	function automatic logic [BYTE_W-1:0] mark_keep(input logic [MARK_W-1:0] mark);
		logic [BYTE_W-1:0] keep;
		keep = 8'hff;
		if (mark[MARK_HIGH_BIT]) begin
			keep = keep & 8'h0f;
		end
		if (mark[MARK_LOW_BIT]) begin
			keep = keep & 8'hf0;
		end
		return keep;
	endfunction

	// Pattern length in force: zero acts as one, anything above the window as full.
	function automatic int unsigned active_length();
		if (len_reg == '0) begin
			return 1;
		end
		if (len_reg > WIN_DEPTH) begin
			return WIN_DEPTH;
		end
		return 32'(len_reg);
	endfunction

	// Advance the model by one accepted beat and queue the report it causes.
	// Return 1 when the beat changed anything at all.
	function automatic bit predict_report(input scan_beat_t b);
		int unsigned   n;
		int unsigned   k;
		bit            hit;
		match_report_t rep;
		case (b.cmd)
			CMD_LOAD: begin
				sig_bytes[b.idx] = b.pbyte;
				sig_marks[b.idx] = b.pmark;
				return 1'b1;
			end
			CMD_START: begin
				win_bytes = '{default: '0};
				seen_bytes = 0;
				region_closed = 1'b0;
				return 1'b1;
			end
			CMD_SCAN: begin
				if (region_closed) begin
					return 1'b0;
				end
				for (k = WIN_DEPTH - 1; k > 0; k--) begin
					win_bytes[k] = win_bytes[k-1];
				end
				win_bytes[0] = b.dbyte;
				if (seen_bytes < COUNT_TOP) begin
					seen_bytes++;
				end
				n = active_length();
				// Oldest byte of the window lines up with pattern entry zero.
				hit = (seen_bytes >= n);
				for (k = 0; k < n; k++) begin
					if (((win_bytes[n-1-k] ^ sig_bytes[k]) & mark_keep(sig_marks[k])) != '0) begin
						hit = 1'b0;
					end
				end
				if (hit) begin
					rep.found = 1'b1;
					rep.offset = OFFSET_W'(seen_bytes - n);
					pending_reports.push_back(rep);
					region_closed = 1'b1;
				end else if (b.last) begin
					rep.found = 1'b0;
					rep.offset = '0;
					pending_reports.push_back(rep);
					region_closed = 1'b1;
				end
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// Fill every field with noise; callers overwrite what the command uses.
	function automatic scan_beat_t random_beat(input logic [CMD_W-1:0] cmd);
		scan_beat_t b;
		b.cmd   = cmd;
		b.idx   = INDEX_W'($urandom);
		b.pbyte = BYTE_W'($urandom);
		b.pmark = MARK_W'($urandom);
		b.dbyte = BYTE_W'($urandom);
		b.last  = 1'($urandom);
		return b;
	endfunction

	// Offer one beat and hold it until accepted. Call right after a rising edge.
	task automatic send_beat(input scan_beat_t b);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.command        <= b.cmd;
		item_ch.entry_index    <= b.idx;
		item_ch.entry_byte     <= b.pbyte;
		item_ch.entry_wildcard <= b.pmark;
		item_ch.data_byte      <= b.dbyte;
		item_ch.last_byte      <= b.last;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (predict_report(b)) begin
			beats_taken++;
		end
	endtask

	task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] value,
			input logic [MARK_W-1:0] mark);
		scan_beat_t b;
		b = random_beat(CMD_LOAD);
		b.idx = idx;
		b.pbyte = value;
		b.pmark = mark;
		send_beat(b);
	endtask

	task automatic send_start();
		send_beat(random_beat(CMD_START));
	endtask

	task automatic send_scan(input logic [BYTE_W-1:0] value, input logic last);
		scan_beat_t b;
		b = random_beat(CMD_SCAN);
		b.dbyte = value;
		b.last = last;
		send_beat(b);
	endtask

	// Pause the sender until every expected report is back and the block is quiet.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		len_reg = value;
	endtask

	// Reset length and an all-zero pattern: scans before any start still form a region.
	task automatic test_scan_before_start();
		send_scan(8'h5a, 1'b0);
		send_scan(8'h00, 1'b0);
		// Region already reported: this one must be dropped.
		send_scan(8'h00, 1'b1);
	endtask

	task automatic test_commands_and_marks();
		scan_beat_t b;
		b = random_beat(CMD_RESERVED);
		b.last = 1'b1;
		send_beat(b);
		write_length(6'd0);
		send_load(5'd0, 8'hff, 2'b00);
		send_load(5'd31, 8'hff, 2'b11);
		send_start();
		send_scan(8'h00, 1'b1);
		// Match on the flagged last byte reports found, not the miss.
		send_start();
		send_scan(8'hff, 1'b1);
		// Stored values in ignored nibbles are nonzero on purpose.
		write_length(6'd3);
		send_load(5'd0, 8'h12, 2'b00);
		send_load(5'd1, 8'hf3, 2'b01);
		send_load(5'd2, 8'h5c, 2'b10);
		send_start();
		send_scan(8'h99, 1'b0);
		send_scan(8'h12, 1'b0);
		send_scan(8'ha3, 1'b0);
		send_scan(8'h5e, 1'b1);
	endtask

	// Whole-byte wildcards match anything, yet not before the window holds three bytes.
	task automatic test_short_window();
		send_load(5'd0, 8'h81, 2'b11);
		send_load(5'd1, 8'h7e, 2'b11);
		send_load(5'd2, 8'hc3, 2'b11);
		send_start();
		send_scan(8'h11, 1'b0);
		send_scan(8'h22, 1'b1);
		send_start();
		send_scan(8'h33, 1'b0);
		send_scan(8'h44, 1'b0);
		send_scan(8'h55, 1'b0);
	endtask

	// Hold the result side for a long stretch while every region reports at once.
	task automatic test_output_backpressure();
		int unsigned k;
		write_length(6'd1);
		send_load(5'd0, 8'h00, 2'b11);
		calm = 1'b1;
		// Drop valid so the load just taken is not offered a second time.
		item_ch.valid <= 1'b0;
		@(negedge clk);
		long_hold_req = 1'b1;
		@(posedge clk);
		for (k = 0; k < 24; k++) begin
			send_start();
			send_scan(BYTE_W'($urandom), 1'($urandom));
		end
		calm = 1'b0;
	endtask

	// Phases of one length each: load a pattern, then scan regions that mostly
	// carry a planted match with random content in the wildcarded nibbles.
	task automatic test_random_regions();
		logic [LEN_W-1:0]  extremes [5];
		logic [BYTE_W-1:0] region [$];
		logic [BYTE_W-1:0] keep;
		logic [MARK_W-1:0] mark;
		int unsigned       base, phase, span, regions, rlen, spot, r, k, j;
		bit                open;
		extremes = '{6'd0, 6'd63, 6'd32, 6'd33, 6'd1};
		base = beats_taken;
		phase = 0;
		while (beats_taken - base < RANDOM_BEATS) begin
			if (phase < 5) begin
				write_length(extremes[phase]);
			end else begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					write_length(extremes[$urandom_range(0, 4)]);
				end else if (r < 3) begin
					write_length(LEN_W'($urandom_range(7, 31)));
				end else begin
					write_length(LEN_W'($urandom_range(1, 6)));
				end
			end
			phase++;
			calm = ($urandom_range(0, 4) == 0);
			span = active_length();
			for (k = 0; k < span; k++) begin
				r = $urandom_range(0, 3);
				mark = (r < 2) ? 2'b00 : MARK_W'($urandom);
				send_load(INDEX_W'(k), BYTE_W'($urandom), mark);
			end
			regions = (span >= 16) ? 2 : $urandom_range(3, 6);
			for (j = 0; j < regions; j++) begin
				send_start();
				if ($urandom_range(0, 9) < 7) begin
					rlen = $urandom_range(span, span + 12);
				end else begin
					rlen = $urandom_range(1, span + 12);
				end
				region.delete();
				for (k = 0; k < rlen; k++) begin
					region.push_back(BYTE_W'($urandom));
				end
				// Plant the pattern; ignored nibbles get random content.
				if (rlen >= span && $urandom_range(0, 9) < 6) begin
					spot = $urandom_range(0, rlen - span);
					for (k = 0; k < span; k++) begin
						keep = mark_keep(sig_marks[k]);
						region[spot+k] = (sig_bytes[k] & keep) | (BYTE_W'($urandom) & ~keep);
					end
				end
				open = ($urandom_range(0, 9) == 0);
				for (k = 0; k < rlen; k++) begin
					r = $urandom_range(0, 99);
					if (r < 3) begin
						send_beat(random_beat(CMD_RESERVED));
					end else if (r < 6) begin
						// Mid-region load: takes effect on the next compare.
						send_load(INDEX_W'($urandom), BYTE_W'($urandom), MARK_W'($urandom));
					end
					send_scan(region[k], (k == rlen - 1) && !open);
				end
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 3)) send_scan(BYTE_W'($urandom), 1'($urandom));
				end
			end
		end
		calm = 1'b0;
	endtask

	// Result sink: random stalls, plus one long hold-off when a test asks for it.
	initial begin : result_sink
		int unsigned stall_left;
		int unsigned hold_left;
		logic        rdy;
		stall_left = 0;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				stall_left = pick_gap();
			end
			result_ch.ready <= rdy;
		end
	end

	// Compare every result beat against the oldest waiting report.
	always @(posedge clk) begin : report_check
		match_report_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result beat: found=%0b match_offset=%0d",
					result_ch.found, result_ch.match_offset);
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				if (result_ch.found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, result_ch.found);
					mismatch_count++;
				end
				if (result_ch.match_offset !== want.offset) begin
					$error("match_offset: expected %0d, got %0d", want.offset,
						result_ch.match_offset);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : run_limit
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin : main_seq
		item_ch.valid          <= 1'b0;
		item_ch.command        <= CMD_LOAD;
		item_ch.entry_index    <= '0;
		item_ch.entry_byte     <= '0;
		item_ch.entry_wildcard <= '0;
		item_ch.data_byte      <= '0;
		item_ch.last_byte      <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_wdata              <= '0;
		arst_n                 <= 1'b0;
		win_bytes = '{default: '0};
		sig_bytes = '{default: '0};
		sig_marks = '{default: '0};
		seen_bytes = 0;
		region_closed = 1'b0;
		len_reg = LEN_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_scan_before_start();
		test_commands_and_marks();
		test_short_window();
		test_output_backpressure();
		test_random_regions();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
